// File: rtl/tgp_pkg.sv
// Shared types, constants and helper functions for the trilinear grid prolongation block.
// Depends on nothing. Every other file imports it.
package tgp_pkg;

   // Defaults of the top-level parameters.
   localparam int DEF_COARSE_MAX   = 32;
   localparam int DEF_SAMPLE_WIDTH = 32;

   // Fixed field widths of the stream items.
   localparam int COORD_W  = 7;
   localparam int DIM_W    = 6;
   localparam int HI_W     = COORD_W + 1;
   localparam int FINE_W   = 32;
   localparam int CSR_IDX_W = 3;

   // Operation codes carried in the request tuser.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_Z = 3'd5;

   localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_FINISH
   } tgp_state_type;

   // Per-axis settings handed from the register file to the sequencer.
   // hi_* is the largest legal coarse index on that axis.
   typedef struct packed {
      logic [HI_W-1:0] hi_x;
      logic [HI_W-1:0] hi_y;
      logic [HI_W-1:0] hi_z;
      logic            off_x;
      logic            off_y;
      logic            off_z;
   } tgp_cfg_type;

   // Result of the per-axis coarse index pick.
   typedef struct packed {
      logic [COORD_W-1:0] base;
      logic               pair;
      logic               ok;
   } tgp_pick_type;

   // A fine index whose parity differs from the offset copies one coarse point;
   // otherwise it averages the base point and the next one.
   function automatic tgp_pick_type axis_pick(input logic [COORD_W-1:0] f,
                                              input logic off,
                                              input logic [HI_W-1:0] hi);
      tgp_pick_type p;
      logic [HI_W-1:0] t;
      t = {1'b0, f} + {{(HI_W-1){1'b0}}, ~off};
      if (f[0] != off) begin
         p.base = t[HI_W-1:1];
         p.pair = 1'b0;
         p.ok   = ({1'b0, t[HI_W-1:1]} <= hi);
      end else begin
         p.base = {1'b0, f[COORD_W-1:1]};
         p.pair = 1'b1;
         p.ok   = (({2'b0, f[COORD_W-1:1]} + HI_W'(1)) <= hi);
      end
      return p;
   endfunction

endpackage

// File: rtl/trilinear_grid_prolongation.sv
// Top level of the trilinear grid prolongation block: stream ports, register file,
// sequencer and coarse store. Depends on tgp_pkg, tgp_seq and tgp_store.
//
// A load (tuser 0) writes one coarse value in the cycle it is accepted, so loads can
// follow back to back; loads with a coordinate beyond the store are dropped. A query
// (tuser 1) goes straight to the finish state when a needed coarse point is out of
// range, and otherwise reads 1, 2, 4 or 8 coarse points. Every coarse point goes
// through the single read port of the store, one per cycle, into one shared adder,
// followed by the drain state for the last registered read data and the finish state
// for the final shift into the result register. The request side is ready again in
// the cycle the result appears; a result that is not taken holds back the end of the
// next query. The store is not cleared at reset; querying a point never loaded gives
// an undefined value.
module trilinear_grid_prolongation
   import tgp_pkg::*;
#(
   parameter int COARSE_MAX   = DEF_COARSE_MAX,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   localparam int SAMPLE_LSB  = 3 * COORD_W,
   localparam int REQ_DATA_W  = ((SAMPLE_LSB + SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: coord_x[6:0], coord_y[13:7], coord_z[20:14],
   // sample_value[20+SAMPLE_WIDTH:21], zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: operation.
   input  logic                  req_tuser,
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: fine_value[31:0].
   output logic [FINE_W-1:0]     rsp_tdata,
   // Fields from bit 0: out_of_range.
   output logic                  rsp_tuser,
   // Configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_wdata
);

   localparam int SIDE   = COARSE_MAX + 2;
   localparam int DEPTH  = SIDE * SIDE * SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [HI_W-1:0] CMAX_H = HI_W'(COARSE_MAX);

   logic [DIM_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [DIM_W-1:0] dim_x_in, dim_y_in, dim_z_in;
   logic             off_x_ff, off_y_ff, off_z_ff;
   logic             off_x_in, off_y_in, off_z_in;
   logic             csr_write;
   tgp_cfg_type      cfg;

   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [SAMPLE_WIDTH-1:0] mem_rdata;

   // Register writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      dim_x_in = dim_x_ff;
      dim_y_in = dim_y_ff;
      dim_z_in = dim_z_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      off_z_in = off_z_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_DIM_X: dim_x_in = csr_wdata;
            CSR_DIM_Y: dim_y_in = csr_wdata;
            CSR_DIM_Z: dim_z_in = csr_wdata;
            CSR_OFF_X: off_x_in = csr_wdata[0];
            CSR_OFF_Y: off_y_in = csr_wdata[0];
            CSR_OFF_Z: off_z_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_RESET;
         dim_y_ff <= DIM_RESET;
         dim_z_ff <= DIM_RESET;
         off_x_ff <= 1'b0;
         off_y_ff <= 1'b0;
         off_z_ff <= 1'b0;
      end else begin
         dim_x_ff <= dim_x_in;
         dim_y_ff <= dim_y_in;
         dim_z_ff <= dim_z_in;
         off_x_ff <= off_x_in;
         off_y_ff <= off_y_in;
         off_z_ff <= off_z_in;
      end
   end

   // Largest legal coarse index per axis, with the dimension capped at COARSE_MAX.
   always_comb begin
      cfg.hi_x  = ((HI_W'(dim_x_ff) > CMAX_H) ? CMAX_H : HI_W'(dim_x_ff)) + HI_W'(1);
      cfg.hi_y  = ((HI_W'(dim_y_ff) > CMAX_H) ? CMAX_H : HI_W'(dim_y_ff)) + HI_W'(1);
      cfg.hi_z  = ((HI_W'(dim_z_ff) > CMAX_H) ? CMAX_H : HI_W'(dim_z_ff)) + HI_W'(1);
      cfg.off_x = off_x_ff;
      cfg.off_y = off_y_ff;
      cfg.off_z = off_z_ff;
   end

   tgp_seq #(
      .COARSE_MAX   (COARSE_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ADDR_W       (ADDR_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_x      (req_tdata[0 +: COORD_W]),
      .req_y      (req_tdata[COORD_W +: COORD_W]),
      .req_z      (req_tdata[2*COORD_W +: COORD_W]),
      .mem_we     (mem_we),
      .mem_re     (mem_re),
      .mem_addr   (mem_addr),
      .mem_rdata  (mem_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_oor    (rsp_tuser)
   );

   tgp_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_WIDTH)
   ) u_store (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (req_tdata[SAMPLE_LSB +: SAMPLE_WIDTH]),
      .mem_rdata (mem_rdata)
   );

endmodule

// File: rtl/tgp_store.sv
// Single-ported coarse grid store with a registered read port.
// Depends on tgp_pkg (imported for house consistency of widths).
module tgp_store
   import tgp_pkg::*;
#(
   parameter int DEPTH  = 39304,
   parameter int ADDR_W = 16,
   parameter int DATA_W = DEF_SAMPLE_WIDTH
) (
   input  logic              clock,
   input  logic              mem_we,
   input  logic              mem_re,
   input  logic [ADDR_W-1:0] mem_addr,
   input  logic [DATA_W-1:0] mem_wdata,
   output logic [DATA_W-1:0] mem_rdata
);

   logic [DATA_W-1:0] mem_array [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // One shared address: a write, a read, or both together; the sequencer drives only one at a time.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem_array[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// File: rtl/tgp_seq.sv
// Query sequencer: per-axis pick, corner walk over the store, shared accumulator,
// final arithmetic shift and the result register. Depends on tgp_pkg.
module tgp_seq
   import tgp_pkg::*;
#(
   parameter int COARSE_MAX   = DEF_COARSE_MAX,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int ADDR_W       = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tgp_cfg_type             cfg,
   // Request side
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_op,
   input  logic [COORD_W-1:0]      req_x,
   input  logic [COORD_W-1:0]      req_y,
   input  logic [COORD_W-1:0]      req_z,
   // Store port
   output logic                    mem_we,
   output logic                    mem_re,
   output logic [ADDR_W-1:0]       mem_addr,
   input  logic [SAMPLE_WIDTH-1:0] mem_rdata,
   // Result side
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [FINE_W-1:0]       rsp_value,
   output logic                    rsp_oor
);

   localparam int SIDE  = COARSE_MAX + 2;
   localparam int ACC_W = SAMPLE_WIDTH + 3;
   localparam logic [ADDR_W-1:0] SIDE_A    = ADDR_W'(SIDE);
   localparam logic [ADDR_W-1:0] SIDE_SQ_A = ADDR_W'(SIDE * SIDE);
   localparam logic [COORD_W-1:0] SIDE_C   = COORD_W'(SIDE);

   tgp_state_type state_ff, state_in;

   logic [COORD_W-1:0] bx_ff, by_ff, bz_ff;
   logic               px_ff, py_ff, pz_ff;
   logic               ok_ff;
   logic               ci_ff, cj_ff, ck_ff, ci_in, cj_in, ck_in;
   logic               rd_valid_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FINE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_oor_ff, rsp_oor_in;

   tgp_pick_type pick_x, pick_y, pick_z;
   logic         accept;
   logic         is_query;
   logic         in_store;
   logic         last_corner;
   logic         rsp_free;
   logic         finish_now;
   logic [COORD_W-1:0] ax, ay, az;
   logic [1:0]   shamt;
   logic signed [ACC_W-1:0] shifted;
   logic [ACC_W+FINE_W-1:0] shifted_ext;

   // Request decode and per-axis picks.
   assign accept   = req_tvalid && req_tready;
   assign is_query = (req_op == OP_QUERY);
   assign in_store = (req_x < SIDE_C) && (req_y < SIDE_C) && (req_z < SIDE_C);
   assign pick_x   = axis_pick(req_x, cfg.off_x, cfg.hi_x);
   assign pick_y   = axis_pick(req_y, cfg.off_y, cfg.hi_y);
   assign pick_z   = axis_pick(req_z, cfg.off_z, cfg.hi_z);

   assign last_corner = (ci_ff == px_ff) && (cj_ff == py_ff) && (ck_ff == pz_ff);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign finish_now  = (state_ff == S_FINISH) && rsp_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && is_query) begin
               state_in = (pick_x.ok && pick_y.ok && pick_z.ok) ? S_READ : S_FINISH;
            end
         end
         S_READ: begin
            if (last_corner) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      mem_re     = (state_ff == S_READ);
      mem_we     = accept && !is_query && in_store;
   end

   // Store address: the current corner while reading, the request coordinate otherwise.
   always_comb begin
      if (state_ff == S_READ) begin
         ax = bx_ff + COORD_W'(ci_ff);
         ay = by_ff + COORD_W'(cj_ff);
         az = bz_ff + COORD_W'(ck_ff);
      end else begin
         ax = req_x;
         ay = req_y;
         az = req_z;
      end
      mem_addr = ADDR_W'(ax) * SIDE_SQ_A + ADDR_W'(ay) * SIDE_A + ADDR_W'(az);
   end

   // Corner walk: z fastest, then y, then x, skipping axes that copy one point.
   always_comb begin
      ci_in = ci_ff;
      cj_in = cj_ff;
      ck_in = ck_ff;
      if (accept) begin
         ci_in = 1'b0;
         cj_in = 1'b0;
         ck_in = 1'b0;
      end else if (state_ff == S_READ) begin
         if (ck_ff != pz_ff) begin
            ck_in = 1'b1;
         end else begin
            ck_in = 1'b0;
            if (cj_ff != py_ff) begin
               cj_in = 1'b1;
            end else begin
               cj_in = 1'b0;
               ci_in = 1'b1;
            end
         end
      end
   end

   // Shared accumulator takes one stored value per cycle.
   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         acc_in = acc_ff + ACC_W'(signed'(mem_rdata));
      end
   end

   // Weighting by 1/2 per averaged axis is an arithmetic shift of the sum.
   assign shamt       = 2'(px_ff) + 2'(py_ff) + 2'(pz_ff);
   assign shifted     = acc_ff >>> shamt;
   assign shifted_ext = {{FINE_W{shifted[ACC_W-1]}}, shifted};

   // Result register: cleared on a transfer, loaded when a query finishes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_oor_in   = rsp_oor_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish_now) begin
         rsp_valid_in = 1'b1;
         rsp_oor_in   = !ok_ff;
         rsp_value_in = ok_ff ? shifted_ext[FINE_W-1:0] : '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= (state_ff == S_READ);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept && is_query) begin
         bx_ff <= pick_x.base;
         by_ff <= pick_y.base;
         bz_ff <= pick_z.base;
         px_ff <= pick_x.pair;
         py_ff <= pick_y.pair;
         pz_ff <= pick_z.pair;
         ok_ff <= pick_x.ok && pick_y.ok && pick_z.ok;
      end
      ci_ff        <= ci_in;
      cj_ff        <= cj_in;
      ck_ff        <= ck_in;
      acc_ff       <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_oor    = rsp_oor_ff;

   // A read result only follows a cycle spent issuing reads.
   a_rd_after_read: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(state_ff == S_READ))
      else $error("store data arrived without a read");

   // The store is never written while a query walks its corners.
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE))
      else $error("store write during a query");

   // The corner counters never step along an axis that copies a single point.
   a_corner_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ((ci_ff && !px_ff) == 1'b0 && (cj_ff && !py_ff) == 1'b0
                                && (ck_ff && !pz_ff) == 1'b0))
      else $error("corner walk left the interpolation cell");

   // An out-of-range result always carries a zero value.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_value_ff == '0))
      else $error("out-of-range result with nonzero value");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for trilinear_grid_prolongation: coarse loads, fine-point queries and
// register settings, with each query result checked against a typed expectation or a bench predictor.
// Depends on tgp_pkg and the trilinear_grid_prolongation RTL.
module tb_top
   import tgp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SIDE      = DEF_COARSE_MAX + 2;
   localparam int STORE_N   = SIDE * SIDE * SIDE;
   localparam int REQ_W     = ((3 * COORD_W + DEF_SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int DRAIN_CYC = 16;
   localparam int LIMIT     = 600000;
   localparam int PHASES    = 8;
   localparam int PHASE_LEN = 160;
   localparam int DIRECTED  = 25;

   // Register indexes that decode to nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NONE_HI = 3'd7;

   typedef struct packed {
      logic [FINE_W-1:0] value;
      logic              oor;
   } fine_result_type;

   typedef struct {
      logic        op;
      int          x;
      int          y;
      int          z;
      logic [31:0] sample;
      bit          typed;
      logic [31:0] want_value;
      logic        want_oor;
   } stim_row_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [FINE_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DIM_W-1:0]     csr_wdata  = '0;

   // Bench copy of the register file and of the coarse store.
   int          dim_x = 32, dim_y = 32, dim_z = 32;
   bit          off_x = 1'b0, off_y = 1'b0, off_z = 1'b0;
   bit          loaded_map [STORE_N];
   logic [31:0] coarse_copy [STORE_N];

   fine_result_type fine_due [$];
   stim_row_type    stim_rows [DIRECTED];

   int          errors = 0;
   int          items_done = 0;
   int          loads_done = 0;
   int          loads_dropped = 0;
   int          queries_done = 0;
   int          queries_oor = 0;
   int          settings_done = 1;
   int unsigned cycle_count = 0;
   bit          send_quiet = 1'b0;
   bit          recv_quiet = 1'b0;

   trilinear_grid_prolongation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      forever #4 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, fine_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // One coordinate axis: which coarse index is used and whether its neighbor is averaged in.
   // Returns 0 when a needed index lies beyond the halo.
   function automatic bit axis_span(input int f, input bit off, input int dim,
                                    output int base, output int pair);
      int hi;
      hi = ((dim > DEF_COARSE_MAX) ? DEF_COARSE_MAX : dim) + 1;
      base = 0;
      pair = 0;
      if ((f & 1) == (1 - off)) begin
         base = (f + 1 - off) >> 1;
         return base <= hi;
      end
      if (f < off) return 1'b0;
      base = (f - off) >> 1;
      pair = 1;
      return base + 1 <= hi;
   endfunction

   function automatic int store_addr(input int x, input int y, input int z);
      return (x * SIDE + y) * SIDE + z;
   endfunction

   // Expected value of one fine point: sum of the coarse points, floor-divided by their count.
   function automatic fine_result_type interpolate_fine(input int fx, input int fy,
                                                        input int fz);
      fine_result_type r;
      int              bx, by, bz, px, py, pz;
      bit              okx, oky, okz;
      longint          acc;
      okx = axis_span(fx, off_x, dim_x, bx, px);
      oky = axis_span(fy, off_y, dim_y, by, py);
      okz = axis_span(fz, off_z, dim_z, bz, pz);
      r.value = '0;
      r.oor   = 1'b1;
      if (okx && oky && okz) begin
         acc = 0;
         for (int i = 0; i <= px; i++)
            for (int j = 0; j <= py; j++)
               for (int k = 0; k <= pz; k++)
                  acc += longint'($signed(coarse_copy[store_addr(bx + i, by + j, bz + k)]));
         acc = acc >>> (px + py + pz);
         r.value = acc[31:0];
         r.oor   = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'($urandom_range(0, 255)) - 32'd128;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_dim();
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, 6);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("Mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      errors++;
   endtask

   // Result side: pace tready and check each transfer against the oldest expectation.
   always @(posedge clock) begin : rsp_side
      int unsigned     stall;
      fine_result_type want;
      if (reset) begin
         rsp_tready <= 1'b1;
         stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fine_due.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 32'h0);
            end else begin
               want = fine_due.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("fine_value", rsp_tdata, want.value);
               if (rsp_tuser !== want.oor)
                  report_mismatch("out_of_range", 32'(rsp_tuser), 32'(want.oor));
            end
            stall = recv_quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            if (stall == 0) rsp_tready <= 1'b1;
         end
      end
   end

   // One register write; valid is dropped only after the last write of a series.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] data,
                            input bit final_write);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DIM_X: dim_x = data;
         CSR_DIM_Y: dim_y = data;
         CSR_DIM_Z: dim_z = data;
         CSR_OFF_X: off_x = data[0];
         CSR_OFF_Y: off_y = data[0];
         CSR_OFF_Z: off_z = data[0];
         default: ;
      endcase
      if (final_write) csr_valid <= 1'b0;
   endtask

   // Offsets go out with random upper bits, which the block must ignore.
   task automatic set_phase(input int dx, input int dy, input int dz,
                            input bit ox, input bit oy, input bit oz);
      write_reg(CSR_DIM_X, dx[DIM_W-1:0], 1'b0);
      write_reg(CSR_DIM_Y, dy[DIM_W-1:0], 1'b0);
      write_reg(CSR_DIM_Z, dz[DIM_W-1:0], 1'b0);
      write_reg(CSR_OFF_X, {5'($urandom), ox}, 1'b0);
      write_reg(CSR_OFF_Y, {5'($urandom), oy}, 1'b0);
      write_reg(CSR_OFF_Z, {5'($urandom), oz}, 1'b1);
      settings_done++;
   endtask

   // Present one request, wait for its transfer, update the prediction, then idle a while.
   task automatic push_item(input logic op, input int x, input int y, input int z,
                            input logic [31:0] sample, input bit typed,
                            input fine_result_type typed_want);
      logic [REQ_W-1:0] d;
      fine_result_type  r;
      int unsigned      gap;
      bit               in_grid;
      d = '0;
      d[COORD_W-1:0]           = x[COORD_W-1:0];
      d[2*COORD_W-1:COORD_W]   = y[COORD_W-1:0];
      d[3*COORD_W-1:2*COORD_W] = z[COORD_W-1:0];
      d[3*COORD_W+31:3*COORD_W] = sample;
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      if (op == OP_LOAD) begin
         in_grid = (x < SIDE) && (y < SIDE) && (z < SIDE);
         if (in_grid) begin
            coarse_copy[store_addr(x, y, z)] = sample;
            loaded_map[store_addr(x, y, z)]  = 1'b1;
            loads_done++;
            items_done++;
         end else begin
            loads_dropped++;
         end
      end else begin
         r = typed ? typed_want : interpolate_fine(x, y, z);
         fine_due.push_back(r);
         queries_done++;
         items_done++;
         if (r.oor) queries_oor++;
      end
      gap = send_quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Query one fine point; coarse points it needs that were never loaded are loaded first,
   // and now and then a needed point gets a fresh value.
   task automatic issue_query(input int fx, input int fy, input int fz);
      int              bx, by, bz, px, py, pz, a;
      bit              okx, oky, okz;
      fine_result_type none;
      none = '0;
      okx = axis_span(fx, off_x, dim_x, bx, px);
      oky = axis_span(fy, off_y, dim_y, by, py);
      okz = axis_span(fz, off_z, dim_z, bz, pz);
      if (okx && oky && okz) begin
         for (int i = 0; i <= px; i++)
            for (int j = 0; j <= py; j++)
               for (int k = 0; k <= pz; k++) begin
                  a = store_addr(bx + i, by + j, bz + k);
                  if (!loaded_map[a] || $urandom_range(0, 15) == 0)
                     push_item(OP_LOAD, bx + i, by + j, bz + k, pick_sample(), 1'b0, none);
               end
      end
      push_item(OP_QUERY, fx, fy, fz, $urandom, 1'b0, none);
   endtask

   // Stop sending and let every expected result arrive, plus time for a trailing load.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (fine_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Main sequence: directed rows at reset settings, then random phases over several settings.
   initial begin : stimulus
      fine_result_type want;
      int              span_x, span_y, span_z, choice, phase_start;
      bit              paused;
      stim_rows = '{
         '{OP_LOAD,    1,   1,   1, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   1,   1,   1, 32'h0,         1'b1, 32'h7FFF_FFFF, 1'b0},
         '{OP_LOAD,    1,   1,   1, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   1,   1,   1, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0},
         '{OP_LOAD,   33,  33,  33, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,  65,  65,  65, 32'h0,         1'b1, 32'h0001_0000, 1'b0},
         '{OP_QUERY,  66,  65,  65, 32'h0,         1'b1, 32'h0, 1'b1},
         '{OP_QUERY, 127, 127, 127, 32'h0,         1'b1, 32'h0, 1'b1},
         '{OP_LOAD,   34,   0,   0, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,  127, 127, 127, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,  65,  65,  65, 32'h0,         1'b1, 32'h0001_0000, 1'b0},
         '{OP_LOAD,    0,   0,   0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    0,   0,   1, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    0,   1,   0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    0,   1,   1, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    1,   0,   0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    1,   0,   1, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    1,   1,   0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   0,   0,   0, 32'h0,         1'b1, 32'h8000_0000, 1'b0},
         '{OP_LOAD,    1,   1,   1, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   0,   0,   0, 32'h0,         1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   0,   1,   1, 32'h0,         1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   0,   0,   1, 32'h0,         1'b0, 32'h0, 1'b0},
         '{OP_LOAD,    0,   1,   1, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
         '{OP_QUERY,   0,   1,   1, 32'h0,         1'b0, 32'h0, 1'b0}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Writes to undecoded indexes must leave the reset settings alone.
      write_reg(CSR_NONE_LO, 6'h3F, 1'b0);
      write_reg(CSR_NONE_HI, 6'h01, 1'b1);

      foreach (stim_rows[i]) begin
         want.value = stim_rows[i].want_value;
         want.oor   = stim_rows[i].want_oor;
         push_item(stim_rows[i].op, stim_rows[i].x, stim_rows[i].y, stim_rows[i].z,
                   stim_rows[i].sample, stim_rows[i].typed, want);
      end
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_phase(1, 1, 1, 1'b0, 1'b0, 1'b0);
            1: set_phase(0, 0, 0, 1'b1, 1'b1, 1'b1);
            2: set_phase(63, 63, 63, 1'b1, 1'b0, 1'b1);
            3: set_phase(32, 32, 32, 1'b1, 1'b1, 1'b1);
            default: set_phase(pick_dim(), pick_dim(), pick_dim(), 1'($urandom),
                               1'($urandom), 1'($urandom));
         endcase
         span_x = 2 * ((dim_x > DEF_COARSE_MAX) ? DEF_COARSE_MAX : dim_x) + 3;
         span_y = 2 * ((dim_y > DEF_COARSE_MAX) ? DEF_COARSE_MAX : dim_y) + 3;
         span_z = 2 * ((dim_z > DEF_COARSE_MAX) ? DEF_COARSE_MAX : dim_z) + 3;
         phase_start = items_done;
         paused = 1'b0;
         while (items_done - phase_start < PHASE_LEN) begin
            // Switch idling on and off in stretches.
            if ($urandom_range(0, 31) == 0) begin
               send_quiet = ($urandom_range(0, 3) == 0);
               recv_quiet = ($urandom_range(0, 3) == 0);
            end
            // Mid-phase, hold the sender until all results are back.
            if (!paused && items_done - phase_start >= PHASE_LEN / 2) begin
               wait_idle();
               paused = 1'b1;
            end
            choice = $urandom_range(0, 99);
            if (choice < 72)
               issue_query($urandom_range(0, span_x), $urandom_range(0, span_y),
                           $urandom_range(0, span_z));
            else if (choice < 84)
               issue_query($urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 127));
            else if (choice < 94)
               push_item(OP_LOAD, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                         $urandom_range(0, SIDE - 1), pick_sample(), 1'b0, '0);
            else
               push_item(OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom, 1'b0, '0);
         end
         wait_idle();
      end

      $display("Run covered %0d coarse loads (%0d dropped outside the store) and %0d queries",
               loads_done, loads_dropped, queries_done);
      $display("(%0d out of range) across %0d register settings, %0d mismatches.",
               queries_oor, settings_done, errors);
      if (errors == 0 && fine_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/tgp_pkg.sv
rtl/tgp_store.sv
rtl/tgp_seq.sv
rtl/trilinear_grid_prolongation.sv
tb/tb_top.sv
